### rtl/assert_macros.svh
// Concurrent check helpers, clocked on clk and quiet in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property that must hold at every edge.
`define HTW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen.
`define HTW_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### rtl/htw_pkg.sv
package htw_pkg;

	localparam int SCAN_STEP = 8;
	localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;

	localparam logic [1:0] ACT_SCHED  = 2'd0;
	localparam logic [1:0] ACT_CANCEL = 2'd1;
	localparam logic [1:0] ACT_TICK   = 2'd2;

	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_EXP  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_SCH_RD, S_SCH_CHK,
		S_UN_RD, S_UN_BK, S_UN_P, S_UN_N,
		S_ARM, S_PL_CALC, S_PL_RD, S_PL_WR, S_PL_LINK,
		S_TICK, S_CAS_RD, S_CAS_CLR, S_CAS_WALK, S_CAS_REC,
		S_EM_RD, S_EM_CLR, S_EM_WALK, S_EM_REC, S_SCAN, S_ACK
	} state_t;

	typedef enum logic [1:0] {R_ACK, R_CAS, R_EM} ret_t;

endpackage

### rtl/hierarchical_timer_wheel_unit.sv
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------
// command  | start, busy        | action, timer_id, delay_ticks, repeating
// result   | strobe (1 cycle)   | kind, expired_id, remain_ticks, last
//
// Schedule or cancel: busy time is set by the bucket and timer RAM
// read-modify-writes of unlink and append; an unknown action is only acked.
// Tick: busy for the cascade of upper buckets visited on a wrap, the walk
// over expired timers (repeating ones are re-armed) and the bitmap scan, 8
// slots a cycle. The final beat comes in the first cycle with busy low.
// After reset the bucket RAM is cleared with busy high. The receiver
// cannot hold results off.
module hierarchical_timer_wheel_unit #(
	parameter int SLOTS = 256,
	parameter int LEVELS = 4,
	parameter int TIMERS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [4:0]  timer_id,
	input  logic [31:0] delay_ticks,
	input  logic        repeating,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [4:0]  expired_id,
	output logic [8:0]  remain_ticks,
	output logic        last
);
	import htw_pkg::*;

	localparam int SB = $clog2(SLOTS);
	localparam int LVW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int BDEPTH = LEVELS * SLOTS;
	localparam int BAW = $clog2(BDEPTH);
	localparam int IDW = $clog2(TIMERS + 1);
	localparam int TIW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam logic [IDW-1:0] NIL = '1;

	typedef struct packed {
		logic [31:0]    fire;
		logic [31:0]    delay;
		logic [BAW-1:0] place;
		logic [IDW-1:0] nxt;
		logic [IDW-1:0] prv;
	} trec_t;

	typedef struct packed {
		logic [IDW-1:0] head;
		logic [IDW-1:0] tail;
	} bkt_t;

	state_t state_q, state_d;
	ret_t ret_q;

	logic            sched_q;
	logic [IDW-1:0]  id_q;
	logic [31:0]     delay_q;
	logic            rep_in_q;
	trec_t           rec_q;
	logic [IDW-1:0]  cur_q;
	logic [IDW-1:0]  tl_q;
	logic            bump_q;
	logic            lv0_q;
	logic [LVW-1:0]  lv_q;
	logic [SB-1:0]   idx_q;
	logic [SB:0]     d_q;
	logic [BAW-1:0]  clr_q;
	logic [31:0]     now_q;
	logic [TIMERS-1:0] pend_q;
	logic [TIMERS-1:0] rep_q;
	logic [SLOTS-1:0]  map_q;

	logic        strobe_q, last_q;
	logic [1:0]  kind_q;
	logic [4:0]  xid_q;
	logic [8:0]  rem_q;

	logic           b_we, t_we;
	logic [BAW-1:0] b_waddr, b_raddr;
	logic [IDW-1:0] t_waddr, t_raddr;
	bkt_t           b_wdata, b_rd;
	trec_t          t_wdata, t_rd, t_mod;

	logic [31:0]    pl_fire;
	logic [BAW-1:0] pl_bk;
	logic           pl_lv0;

	logic [SB-1:0]  cas_slot;
	logic [BAW-1:0] cas_bk, em_bk;
	logic [IDW-1:0] un_head;
	logic           id_ok;
	logic           hit;
	logic [SB-1:0]  hj;
	logic [SB-1:0]  pos;
	logic           scan_end;

	logic       em_v, em_last;
	logic [1:0] em_kind;
	logic [4:0] em_id;
	logic [8:0] em_rem;

	htw_ram #(.WIDTH($bits(bkt_t)), .DEPTH(BDEPTH)) u_bkt_ram (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rd)
	);

	htw_ram #(.WIDTH($bits(trec_t)), .DEPTH(TIMERS)) u_tmr_ram (
		.clk(clk), .we(t_we), .waddr(t_waddr[TIW-1:0]), .wdata(t_wdata),
		.raddr(t_raddr[TIW-1:0]), .rdata(t_rd)
	);

	htw_place #(.SLOTS(SLOTS), .LEVELS(LEVELS), .BAW(BAW)) u_place (
		.now(now_q), .fire_in(rec_q.fire), .bump(bump_q),
		.fire(pl_fire), .bucket(pl_bk), .level0(pl_lv0)
	);

	assign id_ok = (32'(timer_id) < 32'(TIMERS));

	always_comb begin
		cas_slot = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (lv_q == LVW'(l)) begin
				cas_slot = SB'({32'd0, now_q} >> (SB * l));
			end
		end
	end
	assign cas_bk = {lv_q, cas_slot};
	assign em_bk = {LVW'(0), idx_q};
	assign un_head = (rec_q.prv == NIL) ? rec_q.nxt : b_rd.head;

	// eight slots of the level-0 bitmap a cycle, nearest first
	always_comb begin
		hit = 1'b0;
		hj = '0;
		pos = '0;
		for (int j = SCAN_STEP - 1; j >= 0; j--) begin
			pos = idx_q + d_q[SB-1:0] + SB'(j);
			if (map_q[pos]) begin
				hit = 1'b1;
				hj = SB'(j);
			end
		end
	end
	assign scan_end = ((d_q + (SB+1)'(SCAN_STEP)) == (SB+1)'(SLOTS));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				if (clr_q == BAW'(BDEPTH - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (action == ACT_TICK) state_d = S_TICK;
					else if (id_ok && (action == ACT_SCHED || action == ACT_CANCEL))
						state_d = S_SCH_RD;
					else state_d = S_ACK;
				end
			end
			S_SCH_RD: state_d = S_SCH_CHK;
			S_SCH_CHK: begin
				if (!pend_q[id_q[TIW-1:0]]) state_d = sched_q ? S_ARM : S_ACK;
				else if (sched_q && t_rd.delay == delay_q) state_d = S_ACK;
				else state_d = S_UN_RD;
			end
			S_UN_RD: state_d = S_UN_BK;
			S_UN_BK: begin
				if (rec_q.prv != NIL) state_d = S_UN_P;
				else if (rec_q.nxt != NIL) state_d = S_UN_N;
				else state_d = sched_q ? S_ARM : S_ACK;
			end
			S_UN_P: begin
				if (rec_q.nxt != NIL) state_d = S_UN_N;
				else state_d = sched_q ? S_ARM : S_ACK;
			end
			S_UN_N: state_d = sched_q ? S_ARM : S_ACK;
			S_ARM: state_d = S_PL_CALC;
			S_PL_CALC: state_d = S_PL_RD;
			S_PL_RD: state_d = S_PL_WR;
			S_PL_WR, S_PL_LINK: begin
				if (state_q == S_PL_WR && b_rd.tail != NIL) state_d = S_PL_LINK;
				else begin
					case (ret_q)
						R_CAS: state_d = S_CAS_WALK;
						R_EM: state_d = S_EM_WALK;
						default: state_d = S_ACK;
					endcase
				end
			end
			S_TICK: begin
				if ((now_q[SB-1:0] + SB'(1)) == '0) state_d = S_CAS_RD;
				else state_d = S_EM_RD;
			end
			S_CAS_RD: state_d = S_CAS_CLR;
			S_CAS_CLR: state_d = S_CAS_WALK;
			S_CAS_WALK: begin
				if (cur_q != NIL) state_d = S_CAS_REC;
				else if (cas_slot != '0 || lv_q == LVW'(LEVELS - 1)) state_d = S_EM_RD;
				else state_d = S_CAS_RD;
			end
			S_CAS_REC: state_d = S_PL_CALC;
			S_EM_RD: state_d = S_EM_CLR;
			S_EM_CLR: state_d = S_EM_WALK;
			S_EM_WALK: state_d = (cur_q != NIL) ? S_EM_REC : S_SCAN;
			S_EM_REC: state_d = rep_q[cur_q[TIW-1:0]] ? S_ARM : S_EM_WALK;
			S_SCAN: begin
				if (hit || scan_end) state_d = S_IDLE;
			end
			S_ACK: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		b_we = 1'b0;
		b_waddr = '0;
		b_wdata = '{head: NIL, tail: NIL};
		b_raddr = '0;
		t_we = 1'b0;
		t_waddr = '0;
		t_raddr = '0;
		t_mod = t_rd;
		t_wdata = t_rd;
		em_v = 1'b0;
		em_kind = KIND_ACK;
		em_id = '0;
		em_rem = '0;
		em_last = 1'b0;
		case (state_q)
			S_CLR: begin
				b_we = 1'b1;
				b_waddr = clr_q;
			end
			S_SCH_RD: t_raddr = id_q;
			S_UN_RD: b_raddr = rec_q.place;
			S_UN_BK: begin
				b_we = 1'b1;
				b_waddr = rec_q.place;
				b_wdata.head = un_head;
				b_wdata.tail = (rec_q.nxt == NIL) ? rec_q.prv : b_rd.tail;
				t_raddr = (rec_q.prv != NIL) ? rec_q.prv : rec_q.nxt;
			end
			S_UN_P: begin
				t_mod.nxt = rec_q.nxt;
				t_we = 1'b1;
				t_waddr = rec_q.prv;
				t_wdata = t_mod;
				t_raddr = rec_q.nxt;
			end
			S_UN_N: begin
				t_mod.prv = rec_q.prv;
				t_we = 1'b1;
				t_waddr = rec_q.nxt;
				t_wdata = t_mod;
			end
			S_PL_RD: b_raddr = rec_q.place;
			S_PL_WR: begin
				b_we = 1'b1;
				b_waddr = rec_q.place;
				b_wdata.head = (b_rd.tail == NIL) ? id_q : b_rd.head;
				b_wdata.tail = id_q;
				t_mod = rec_q;
				t_mod.nxt = NIL;
				t_mod.prv = b_rd.tail;
				t_we = 1'b1;
				t_waddr = id_q;
				t_wdata = t_mod;
				t_raddr = b_rd.tail;
			end
			S_PL_LINK: begin
				t_mod.nxt = id_q;
				t_we = 1'b1;
				t_waddr = tl_q;
				t_wdata = t_mod;
			end
			S_CAS_RD: b_raddr = cas_bk;
			S_CAS_CLR: begin
				b_we = 1'b1;
				b_waddr = cas_bk;
			end
			S_CAS_WALK: t_raddr = cur_q;
			S_EM_RD: b_raddr = em_bk;
			S_EM_CLR: begin
				b_we = 1'b1;
				b_waddr = em_bk;
			end
			S_EM_WALK: t_raddr = cur_q;
			S_EM_REC: begin
				em_v = 1'b1;
				em_kind = KIND_EXP;
				em_id = 5'(cur_q);
			end
			S_SCAN: begin
				if (hit || scan_end) begin
					em_v = 1'b1;
					em_kind = KIND_TICK;
					em_last = 1'b1;
					em_rem = hit ? 9'(d_q + (SB+1)'(hj)) : 9'(SLOTS);
				end
			end
			S_ACK: begin
				em_v = 1'b1;
				em_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q <= R_ACK;
			clr_q <= '0;
			now_q <= '0;
			pend_q <= '0;
			rep_q <= '0;
			map_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe_q <= em_v;
			case (state_q)
				S_CLR: clr_q <= clr_q + BAW'(1);
				S_IDLE: ret_q <= R_ACK;
				S_UN_BK: begin
					pend_q[id_q[TIW-1:0]] <= 1'b0;
					if (rec_q.place[BAW-1:SB] == '0 && un_head == NIL)
						map_q[rec_q.place[SB-1:0]] <= 1'b0;
				end
				S_ARM: begin
					pend_q[id_q[TIW-1:0]] <= 1'b1;
					if (ret_q == R_ACK) rep_q[id_q[TIW-1:0]] <= rep_in_q;
				end
				S_PL_WR: begin
					if (lv0_q) map_q[rec_q.place[SB-1:0]] <= 1'b1;
				end
				S_TICK: now_q <= now_q + 32'd1;
				S_CAS_CLR: ret_q <= R_CAS;
				S_EM_CLR: begin
					ret_q <= R_EM;
					map_q[idx_q] <= 1'b0;
				end
				S_EM_REC: pend_q[cur_q[TIW-1:0]] <= 1'b0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= em_kind;
		xid_q <= em_id;
		rem_q <= em_rem;
		last_q <= em_last;
		case (state_q)
			S_IDLE: begin
				sched_q <= (action == ACT_SCHED);
				id_q <= IDW'(timer_id);
				delay_q <= delay_ticks;
				rep_in_q <= repeating;
			end
			S_SCH_CHK: rec_q <= t_rd;
			S_ARM: begin
				rec_q.delay <= delay_q;
				rec_q.fire <= now_q + delay_q;
				bump_q <= 1'b1;
			end
			S_PL_CALC: begin
				rec_q.fire <= pl_fire;
				rec_q.place <= pl_bk;
				lv0_q <= pl_lv0;
			end
			S_PL_WR: tl_q <= b_rd.tail;
			S_TICK: begin
				idx_q <= now_q[SB-1:0] + SB'(1);
				lv_q <= LVW'(1);
			end
			S_CAS_CLR, S_EM_CLR: cur_q <= b_rd.head;
			S_CAS_WALK: begin
				if (cur_q == NIL) lv_q <= lv_q + LVW'(1);
			end
			S_CAS_REC: begin
				rec_q <= t_rd;
				id_q <= cur_q;
				cur_q <= t_rd.nxt;
				bump_q <= 1'b0;
			end
			S_EM_WALK: d_q <= '0;
			S_EM_REC: begin
				rec_q <= t_rd;
				id_q <= cur_q;
				cur_q <= t_rd.nxt;
				delay_q <= t_rd.delay;
			end
			S_SCAN: d_q <= d_q + (SB+1)'(SCAN_STEP);
			default: begin
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign kind = kind_q;
	assign expired_id = xid_q;
	assign remain_ticks = rem_q;
	assign last = last_q;

	`include "assert_macros.svh"

	`HTW_ASSERT(a_last_frees, strobe && last |-> !busy, "final beat while still busy")
	`HTW_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted command left block idle")
	`HTW_NEVER(a_exp_not_last, strobe && kind == KIND_EXP && last, "expiry beat marked last")
	`HTW_NEVER(a_clr_no_beat, state_q == S_CLR && strobe, "beat during bucket clear")
endmodule

### rtl/htw_ram.sv
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/htw_place.sv
module htw_place #(
	parameter int SLOTS = 256,
	parameter int LEVELS = 4,
	parameter int BAW = 10
) (
	input  logic [31:0]    now,
	input  logic [31:0]    fire_in,
	input  logic           bump,
	output logic [31:0]    fire,
	output logic [BAW-1:0] bucket,
	output logic           level0
);
	import htw_pkg::*;

	localparam int SB = $clog2(SLOTS);
	localparam int LVW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	logic [31:0] f;
	logic [63:0] el64;
	logic [63:0] f64;
	logic [LVW-1:0] lv;
	logic [SB-1:0] slot;

	always_comb begin
		f = fire_in;
		if ((fire_in - now) > HALF_RANGE) begin
			f = now;
		end
		if (bump && f == now) begin
			f = now + 32'd1;
		end
		el64 = {32'd0, f - now};
		f64 = {32'd0, f};
		// top level takes whatever no lower level holds
		lv = LVW'(LEVELS - 1);
		slot = SB'(f64 >> (SB * (LEVELS - 1)));
		for (int l = LEVELS - 2; l >= 0; l--) begin
			if ((el64 >> (SB * (l + 1))) == 64'd0) begin
				lv = LVW'(l);
				slot = SB'(f64 >> (SB * l));
			end
		end
	end

	assign fire = f;
	assign bucket = {lv, slot};
	assign level0 = (lv == '0);
endmodule
